// ===== hw/rtl/radar_measurement_jacobian_defines.svh =====
// assertion macros for the radar measurement jacobian block
`ifndef RADAR_MEASUREMENT_JACOBIAN_DEFINES_SVH
`define RADAR_MEASUREMENT_JACOBIAN_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/rmj_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_pkg
// Types, constants and helpers shared by the radar measurement jacobian block.
// ----------------------------------------------------------------------------
package rmj_pkg;

   localparam logic [30:0] MIN_SQ_RESET = 31'd7;
   localparam int MUL_STEPS  = 32;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 33;
   localparam logic [2:0] LAST_ENTRY = 3'd5;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] d_range_d_px;
      logic signed [31:0] d_range_d_py;
      logic signed [31:0] d_bearing_d_px;
      logic signed [31:0] d_bearing_d_py;
      logic signed [31:0] d_rate_d_px;
      logic signed [31:0] d_rate_d_py;
      logic               held;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_CHECK,
      ST_SQRT,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C3,
      ST_MUL_NX,
      ST_MUL_NY,
      ST_DIV,
      ST_DONE
   } rmj_state_type;

   typedef struct packed {
      logic mul_start;
      logic sqrt_start;
      logic div_start;
   } rmj_ctl_type;

   // magnitude of a two's complement word
   function automatic logic [31:0] mag32(input logic [31:0] v);
      logic [31:0] r;
      r = v[31] ? (32'd0 - v) : v;
      return r;
   endfunction

endpackage

// ===== hw/rtl/rmj_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_mul
// Bit-serial shift-add multiplier: 64-bit multiplicand, 32-bit multiplier,
// one multiplier bit per cycle, 96-bit product.
// ----------------------------------------------------------------------------
module rmj_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] mcand,
   input  logic [31:0] mplier,
   output logic        done,
   output logic [95:0] prod
);
   import rmj_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [95:0] prod_ff, prod_in;
   logic [63:0] mcand_ff, mcand_in;
   logic [64:0] sum;

   // add the multiplicand into the upper 64 bits when the low bit is set
   always_comb begin
      sum = {1'b0, prod_ff[95:32]} + (prod_ff[0] ? {1'b0, mcand_ff} : 65'd0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = 5'd0;
         prod_in  = {64'd0, mplier};
         mcand_in = mcand;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[31:1]};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // data
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

// ===== hw/rtl/rmj_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_sqrt
// Restoring integer square root, two radicand bits per cycle,
// floor of the root of a 64-bit value.
// ----------------------------------------------------------------------------
module rmj_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import rmj_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] rad_ff, rad_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [34:0] shifted;
   logic [34:0] trial;
   logic        fits;

   // one root bit per step
   always_comb begin
      shifted = {rem_ff, rad_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      fits    = (shifted >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         rad_in  = radicand;
         rem_in  = 33'd0;
         root_in = 32'd0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[61:0], 2'b00};
         rem_in  = fits ? 33'(shifted - trial) : shifted[32:0];
         root_in = {root_ff[30:0], fits};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // data
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== hw/rtl/rmj_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_div
// Restoring divider, one quotient bit per cycle. Gives the signed Q16.16
// quotient of two magnitudes, truncated and saturated to 32 bits.
// ----------------------------------------------------------------------------
module rmj_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] num,
   input  logic [95:0]  den,
   input  logic         neg,
   output logic         done,
   output logic [31:0]  quo
);
   import rmj_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [95:0] pr_ff, pr_in;
   logic [32:0] low_ff, low_in;
   logic [32:0] q_ff, q_in;
   logic [95:0] den_ff, den_in;
   logic        sat_ff, sat_in;
   logic        neg_ff, neg_in;
   logic [96:0] shifted;
   logic        fits;
   logic [32:0] limit;
   logic [32:0] mag;

   // quotient at or above 2^33 is flagged up front, then 33 bits are developed
   always_comb begin
      shifted = {pr_ff, low_ff[32]};
      fits    = (shifted >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      pr_in   = pr_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      sat_in  = sat_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         pr_in   = {1'b0, num[127:33]};
         low_in  = num[32:0];
         q_in    = 33'd0;
         den_in  = den;
         sat_in  = ({1'b0, num[127:33]} >= den);
         neg_in  = neg;
      end else if (busy_ff) begin
         pr_in  = fits ? 96'(shifted - {1'b0, den_ff}) : shifted[95:0];
         low_in = {low_ff[31:0], 1'b0};
         q_in   = {q_ff[31:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // saturate and apply sign
   always_comb begin
      limit = neg_ff ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      mag   = (sat_ff || (q_ff > limit)) ? limit : q_ff;
      quo   = neg_ff ? (32'd0 - mag[31:0]) : mag[31:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // data
   always_ff @(posedge clock) begin
      pr_ff  <= pr_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      sat_ff <= sat_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;

endmodule

// ===== hw/rtl/radar_measurement_jacobian.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// Radar measurement Jacobian of a tracked state, bit-serial arithmetic.
// ----------------------------------------------------------------------------
// One state beat goes in, one Jacobian beat comes out. The block works on one
// beat at a time: a normal update runs seven serial multiplies, a serial square
// root and six serial divisions that share one multiplier and one divider. When
// the squared range is zero or below min_squared_range, the stored Jacobian is
// repeated with held set. A finished beat waits in the output register while
// the next state beat is taken. Write csr_wr_data only while the block is idle.
module radar_measurement_jacobian (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [30:0]      csr_wr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  rmj_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rmj_pkg::rsp_type rsp_data
);
   import rmj_pkg::*;
`include "radar_measurement_jacobian_defines.svh"

   rmj_state_type state_ff, state_in;
   rmj_ctl_type   ctl;
   logic          launched_ff, launched_in;
   logic [30:0]   min_ff;
   req_type       in_ff;
   logic [31:0]   ax_ff, ay_ff;
   logic [63:0]   c_ff, p1_ff, ad_ff;
   logic          s1_ff, dneg_ff, held_ff;
   logic [31:0]   s_ff;
   logic [95:0]   c3_ff, nx_ff, ny_ff;
   logic [31:0]   jac_ff [6];
   logic [2:0]    div_idx_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   logic          mul_done, sqrt_done, div_done, unit_done;
   logic [63:0]   mul_a;
   logic [31:0]   mul_b;
   logic [95:0]   mul_p;
   logic [31:0]   sqrt_root;
   logic [127:0]  div_num;
   logic [95:0]   div_den;
   logic          div_neg;
   logic [31:0]   div_quo;
   logic          small_range;
   logic          capture;
   logic          load_rsp;
   logic          mul_state;
   logic [64:0]   d_val;
   logic          s2;

   assign unit_done   = mul_done | sqrt_done | div_done;
   assign capture     = launched_ff && unit_done;
   assign small_range = (c_ff == 64'd0) || (c_ff < {17'd0, min_ff, 16'd0});
   assign mul_state   = (state_ff == ST_SQ_X) || (state_ff == ST_SQ_Y) ||
                        (state_ff == ST_MUL_A) || (state_ff == ST_MUL_B) ||
                        (state_ff == ST_MUL_C3) || (state_ff == ST_MUL_NX) ||
                        (state_ff == ST_MUL_NY);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SQ_X;
         ST_SQ_X:   if (capture) state_in = ST_SQ_Y;
         ST_SQ_Y:   if (capture) state_in = ST_CHECK;
         ST_CHECK:  state_in = small_range ? ST_DONE : ST_SQRT;
         ST_SQRT:   if (capture) state_in = ST_MUL_A;
         ST_MUL_A:  if (capture) state_in = ST_MUL_B;
         ST_MUL_B:  if (capture) state_in = ST_MUL_C3;
         ST_MUL_C3: if (capture) state_in = ST_MUL_NX;
         ST_MUL_NX: if (capture) state_in = ST_MUL_NY;
         ST_MUL_NY: if (capture) state_in = ST_DIV;
         ST_DIV:    if (capture && (div_idx_ff == LAST_ENTRY)) state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // unit launch controls
   always_comb begin
      ctl.mul_start  = mul_state && !launched_ff;
      ctl.sqrt_start = (state_ff == ST_SQRT) && !launched_ff;
      ctl.div_start  = (state_ff == ST_DIV) && !launched_ff;
      launched_in    = (ctl.mul_start || ctl.sqrt_start || ctl.div_start) ||
                       (launched_ff && !unit_done);
      load_rsp       = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // multiplier operands per step
   always_comb begin
      case (state_ff)
         ST_SQ_X:   begin mul_a = {32'd0, ax_ff};            mul_b = ax_ff;            end
         ST_SQ_Y:   begin mul_a = {32'd0, ay_ff};            mul_b = ay_ff;            end
         ST_MUL_A:  begin mul_a = {32'd0, mag32(in_ff.vel_x)}; mul_b = ay_ff;          end
         ST_MUL_B:  begin mul_a = {32'd0, mag32(in_ff.vel_y)}; mul_b = ax_ff;          end
         ST_MUL_C3: begin mul_a = c_ff;                      mul_b = s_ff;             end
         ST_MUL_NX: begin mul_a = ad_ff;                     mul_b = ax_ff;            end
         ST_MUL_NY: begin mul_a = ad_ff;                     mul_b = ay_ff;            end
         default:   begin mul_a = 64'd0;                     mul_b = 32'd0;            end
      endcase
   end

   // divider operands per entry
   always_comb begin
      case (div_idx_ff)
         3'd0: begin
            div_num = {80'd0, ax_ff, 16'd0};
            div_den = {64'd0, s_ff};
            div_neg = in_ff.pos_x[31];
         end
         3'd1: begin
            div_num = {80'd0, ay_ff, 16'd0};
            div_den = {64'd0, s_ff};
            div_neg = in_ff.pos_y[31];
         end
         3'd2: begin
            div_num = {64'd0, ay_ff, 32'd0};
            div_den = {32'd0, c_ff};
            div_neg = !in_ff.pos_y[31] && (in_ff.pos_y != 32'sd0);
         end
         3'd3: begin
            div_num = {64'd0, ax_ff, 32'd0};
            div_den = {32'd0, c_ff};
            div_neg = in_ff.pos_x[31];
         end
         3'd4: begin
            div_num = {16'd0, ny_ff, 16'd0};
            div_den = c3_ff;
            div_neg = (ad_ff != 64'd0) && (in_ff.pos_y[31] != dneg_ff);
         end
         3'd5: begin
            div_num = {16'd0, nx_ff, 16'd0};
            div_den = c3_ff;
            div_neg = (ad_ff != 64'd0) && (in_ff.pos_x[31] == dneg_ff);
         end
         default: begin
            div_num = 128'd0;
            div_den = 96'd1;
            div_neg = 1'b0;
         end
      endcase
   end

   // signed cross term vx*py - vy*px from the two magnitudes
   always_comb begin
      s2    = in_ff.vel_y[31] ^ in_ff.pos_x[31];
      d_val = (s1_ff ? (65'd0 - {1'b0, p1_ff}) : {1'b0, p1_ff}) -
              (s2 ? (65'd0 - {1'b0, mul_p[63:0]}) : {1'b0, mul_p[63:0]});
   end

   rmj_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.mul_start),
      .mcand  (mul_a),
      .mplier (mul_b),
      .done   (mul_done),
      .prod   (mul_p)
   );

   rmj_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.sqrt_start),
      .radicand (c_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   rmj_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.div_start),
      .num   (div_num),
      .den   (div_den),
      .neg   (div_neg),
      .done  (div_done),
      .quo   (div_quo)
   );

   // control registers, stored jacobian and output beat valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         min_ff       <= MIN_SQ_RESET;
         div_idx_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) jac_ff[i] <= 32'd0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
         if (csr_wr_en) min_ff <= csr_wr_data;
         if ((state_ff == ST_DIV) && capture) begin
            jac_ff[div_idx_ff] <= div_quo;
            div_idx_ff <= (div_idx_ff == LAST_ENTRY) ? 3'd0 : div_idx_ff + 3'd1;
         end
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath captures
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         in_ff <= req_data;
         ax_ff <= mag32(req_data.pos_x);
         ay_ff <= mag32(req_data.pos_y);
      end
      if (capture) begin
         case (state_ff)
            ST_SQ_X:   c_ff  <= mul_p[63:0];
            ST_SQ_Y:   c_ff  <= c_ff + mul_p[63:0];
            ST_SQRT:   s_ff  <= sqrt_root;
            ST_MUL_A: begin
               p1_ff <= mul_p[63:0];
               s1_ff <= in_ff.vel_x[31] ^ in_ff.pos_y[31];
            end
            ST_MUL_B: begin
               dneg_ff <= d_val[64];
               ad_ff   <= d_val[64] ? 64'(65'd0 - d_val) : d_val[63:0];
            end
            ST_MUL_C3: c3_ff <= mul_p;
            ST_MUL_NX: nx_ff <= mul_p;
            ST_MUL_NY: ny_ff <= mul_p;
            default: ;
         endcase
      end
      if (state_ff == ST_CHECK) held_ff <= small_range;
      if (load_rsp) begin
         rsp_ff.d_range_d_px   <= jac_ff[0];
         rsp_ff.d_range_d_py   <= jac_ff[1];
         rsp_ff.d_bearing_d_px <= jac_ff[2];
         rsp_ff.d_bearing_d_py <= jac_ff[3];
         rsp_ff.d_rate_d_px    <= jac_ff[4];
         rsp_ff.d_rate_d_py    <= jac_ff[5];
         rsp_ff.held           <= held_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `ASSERT_NEXT(a_zero_range_held, clock, reset, (state_ff == ST_CHECK) && (c_ff == 64'd0), (state_ff == ST_DONE) && held_ff)
   `ASSERT_IMPLY(a_done_only_launched, clock, reset, unit_done, launched_ff)
   `ASSERT_IMPLY(a_div_idx_rests, clock, reset, state_ff != ST_DIV, div_idx_ff == 3'd0)

endmodule
